FILE: hw/rtl/chunk_descriptor_byte_queue_macros.svh
// Assertion macros shared by the chunk descriptor byte queue RTL.
`ifndef CHUNK_DESCRIPTOR_BYTE_QUEUE_MACROS_SVH
`define CHUNK_DESCRIPTOR_BYTE_QUEUE_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define CDBQ_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Same-cycle implication, checked out of reset.
`define CDBQ_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/cdbq_pkg.sv
// Shared types and constants of the chunk descriptor byte queue.
package cdbq_pkg;

  localparam int ID_W    = 8;
  localparam int FLD_W   = 16;
  localparam int TOTAL_W = 20;
  localparam int OP_W    = 2;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH    = 2'd0,
    OP_CONSUME = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_RANGE     = 2'd1,
    ST_EXHAUSTED = 2'd2
  } status_t;

  // Classified command handed from the front end to the execution unit
  typedef struct packed {
    op_t                op;
    logic               range_ok;
    logic [ID_W-1:0]    block_id;
    logic [FLD_W-1:0]   offset;
    logic [FLD_W-1:0]   length;
    logic [TOTAL_W-1:0] consume_bytes;
  } cmd_t;

  // Queue status flags reported by the execution unit
  typedef struct packed {
    logic q_empty;
    logic total_zero;
  } back_stat_t;

endpackage

FILE: hw/rtl/cdbq_in_if.sv
// Input channel: one queue operation per item.
interface cdbq_in_if import cdbq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic               block_present;
  logic [ID_W-1:0]    block_id;
  logic [FLD_W-1:0]   block_size;
  logic [FLD_W-1:0]   chunk_offset;
  logic [FLD_W-1:0]   chunk_length;
  logic [TOTAL_W-1:0] consume_bytes;

  modport source (
    output valid, operation, block_present, block_id, block_size,
           chunk_offset, chunk_length, consume_bytes,
    input  ready
  );

  modport sink (
    input  valid, operation, block_present, block_id, block_size,
           chunk_offset, chunk_length, consume_bytes,
    output ready
  );
endinterface

FILE: hw/rtl/cdbq_out_if.sv
// Result channel: status, head descriptor and byte total per item.
interface cdbq_out_if import cdbq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic               front_valid;
  logic [ID_W-1:0]    front_block;
  logic [FLD_W-1:0]   front_offset;
  logic [FLD_W-1:0]   front_length;
  logic [TOTAL_W-1:0] queued_total;

  modport source (
    output valid, status, front_valid, front_block, front_offset,
           front_length, queued_total,
    input  ready
  );

  modport sink (
    input  valid, status, front_valid, front_block, front_offset,
           front_length, queued_total,
    output ready
  );
endinterface

FILE: hw/rtl/cdbq_front.sv
// Front end: accepts items, range-checks pushes and buffers commands.
module cdbq_front import cdbq_pkg::*; #(
  parameter int LEN_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  cdbq_in_if.sink   in_chan,
  output logic      cmd_valid,
  output cmd_t      cmd,
  input  logic      cmd_ready
);

  localparam int LW = LEN_BITS;

  logic [LW-1:0] size_l;
  logic [LW-1:0] off_l;
  logic [LW-1:0] len_l;
  logic          range_ok;
  cmd_t          new_cmd;

  cmd_t          q_r [2];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    cnt_r;
  logic          push;
  logic          pop;

  // Fields are taken modulo 2^LEN_BITS before checking
  assign size_l = LW'(in_chan.block_size);
  assign off_l  = LW'(in_chan.chunk_offset);
  assign len_l  = LW'(in_chan.chunk_length);

  // Chunk must be non-empty and lie inside its block
  assign range_ok = in_chan.block_present && (len_l != '0) && (off_l <= size_l) &&
                    (len_l <= LW'(size_l - off_l));

  always_comb begin
    new_cmd               = '0;
    new_cmd.op            = op_t'(in_chan.operation);
    new_cmd.range_ok      = range_ok;
    new_cmd.block_id      = in_chan.block_id;
    new_cmd.offset        = FLD_W'(off_l);
    new_cmd.length        = FLD_W'(len_l);
    new_cmd.consume_bytes = in_chan.consume_bytes;
  end

  // Two-entry command queue between front end and execution unit
  assign in_chan.ready = (cnt_r != 2'd2);
  assign push          = in_chan.valid && in_chan.ready;
  assign cmd_valid     = (cnt_r != 2'd0);
  assign pop           = cmd_valid && cmd_ready;
  assign cmd           = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= new_cmd;
  end

endmodule

FILE: hw/rtl/cdbq_back.sv
// Execution unit: descriptor store, head trimming sequencer and result register.
module cdbq_back import cdbq_pkg::*; #(
  parameter int DEPTH    = 16,
  parameter int LEN_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cmd_valid,
  input  cmd_t        cmd,
  output logic        cmd_ready,
  cdbq_out_if.source  out_chan,
  output back_stat_t  stat
);

  localparam int LW = LEN_BITS;
  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int DW = ID_W + 2 * LW;
  localparam int SW = ((LW > TOTAL_W) ? LW : TOTAL_W) + 1;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_TRIM  = 3'b010,
    S_FETCH = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [IW-1:0]      head_r, head_nxt;
  logic [IW-1:0]      tail_r, tail_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [TOTAL_W-1:0] rem_r, rem_nxt;
  logic [ID_W-1:0]    hblk_r, hblk_nxt;
  logic [LW-1:0]      hoff_r, hoff_nxt;
  logic [LW-1:0]      hlen_r, hlen_nxt;
  status_t            status_nxt;
  logic               finish;

  logic               ovalid_r;
  status_t            ostatus_r;
  logic               ofv_r;
  logic [ID_W-1:0]    oblk_r;
  logic [FLD_W-1:0]   ooff_r;
  logic [FLD_W-1:0]   olen_r;
  logic [TOTAL_W-1:0] ototal_r;

  logic [DW-1:0]      desc_mem_r [DEPTH];
  logic [DW-1:0]      rd_data_r;
  logic               mem_we;

  logic               slot_free;
  logic               take;
  logic [LW-1:0]      c_off;
  logic [LW-1:0]      c_len;
  logic [SW-1:0]      push_sum;
  logic               push_ovf;
  logic [TOTAL_W-1:0] clamp_bytes;
  logic               rem_lt;

  function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] i);
    return (i == IW'(DEPTH - 1)) ? '0 : IW'(i + 1'b1);
  endfunction

  // A command starts only when the result register can take its result
  assign slot_free = !ovalid_r || out_chan.ready;
  assign cmd_ready = (state_r == S_IDLE) && slot_free;
  assign take      = cmd_valid && cmd_ready;

  assign c_off       = LW'(cmd.offset);
  assign c_len       = LW'(cmd.length);
  assign push_sum    = SW'(total_r) + SW'(c_len);
  assign push_ovf    = push_sum > SW'(TOTAL_MAX);
  assign clamp_bytes = (cmd.consume_bytes > total_r) ? total_r : cmd.consume_bytes;
  assign rem_lt      = SW'(rem_r) < SW'(hlen_r);

  // Sequencer: push, clear in one step; consume trims/pops one head per step
  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    total_nxt  = total_r;
    rem_nxt    = rem_r;
    hblk_nxt   = hblk_r;
    hoff_nxt   = hoff_r;
    hlen_nxt   = hlen_r;
    status_nxt = ST_OK;
    finish     = 1'b0;
    mem_we     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (take) begin
          case (cmd.op)
            OP_PUSH: begin
              finish = 1'b1;
              if (!cmd.range_ok) begin
                status_nxt = ST_RANGE;
              end else if ((count_r == CW'(DEPTH)) || push_ovf) begin
                status_nxt = ST_EXHAUSTED;
              end else begin
                mem_we    = 1'b1;
                tail_nxt  = next_idx(tail_r);
                count_nxt = CW'(count_r + 1'b1);
                total_nxt = TOTAL_W'(push_sum);
                // first entry also becomes the cached head
                if (count_r == '0) begin
                  hblk_nxt = cmd.block_id;
                  hoff_nxt = c_off;
                  hlen_nxt = c_len;
                end
              end
            end
            OP_CONSUME: begin
              if (clamp_bytes == '0) begin
                finish = 1'b1;
              end else begin
                rem_nxt   = clamp_bytes;
                state_nxt = S_TRIM;
              end
            end
            OP_CLEAR: begin
              head_nxt  = '0;
              tail_nxt  = '0;
              count_nxt = '0;
              total_nxt = '0;
              finish    = 1'b1;
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
      end
      S_TRIM: begin
        if (rem_lt) begin
          // partial trim of the head chunk ends the consume
          hoff_nxt  = LW'(hoff_r + LW'(rem_r));
          hlen_nxt  = LW'(hlen_r - LW'(rem_r));
          total_nxt = TOTAL_W'(total_r - rem_r);
          rem_nxt   = '0;
          finish    = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          // head chunk used up: pop it
          rem_nxt   = TOTAL_W'(rem_r - TOTAL_W'(hlen_r));
          total_nxt = TOTAL_W'(total_r - TOTAL_W'(hlen_r));
          head_nxt  = next_idx(head_r);
          count_nxt = CW'(count_r - 1'b1);
          if (count_r == CW'(1)) begin
            finish    = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        // new head arrives from the store
        hblk_nxt = rd_data_r[DW-1 -: ID_W];
        hoff_nxt = rd_data_r[2*LW-1 -: LW];
        hlen_nxt = rd_data_r[LW-1:0];
        if (rem_r == '0) begin
          finish    = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_TRIM;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      total_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      total_r <= total_nxt;
    end
  end

  // Cached head descriptor and remaining consume count
  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    hblk_r <= hblk_nxt;
    hoff_r <= hoff_nxt;
    hlen_r <= hlen_nxt;
  end

  // Descriptor store: write at tail, registered read at the next head
  always_ff @(posedge clk) begin
    if (mem_we) desc_mem_r[tail_r] <= {cmd.block_id, c_off, c_len};
    rd_data_r <= desc_mem_r[head_nxt];
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (finish) begin
      ovalid_r <= 1'b1;
    end else if (out_chan.ready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      ostatus_r <= status_nxt;
      ofv_r     <= (count_nxt != '0);
      oblk_r    <= (count_nxt != '0) ? hblk_nxt : '0;
      ooff_r    <= (count_nxt != '0) ? FLD_W'(hoff_nxt) : '0;
      olen_r    <= (count_nxt != '0) ? FLD_W'(hlen_nxt) : '0;
      ototal_r  <= total_nxt;
    end
  end

  assign out_chan.valid        = ovalid_r;
  assign out_chan.status       = ostatus_r;
  assign out_chan.front_valid  = ofv_r;
  assign out_chan.front_block  = oblk_r;
  assign out_chan.front_offset = ooff_r;
  assign out_chan.front_length = olen_r;
  assign out_chan.queued_total = ototal_r;

  assign stat.q_empty    = (count_r == '0);
  assign stat.total_zero = (total_r == '0);

endmodule

FILE: hw/rtl/chunk_descriptor_byte_queue.sv
// Top level of the chunk descriptor byte queue.
//
// Scatter-gather byte FIFO holding up to DEPTH chunk descriptors (block id,
// offset, length) and a running total of queued bytes.
// in_chan carries one operation per item: push a descriptor, consume bytes
// from the head, or clear. out_chan returns one result per item: status, the
// head descriptor after the operation and the queued byte total.
// Both channels use valid/ready; an item moves when both are high.
// With the command queue empty, a push, clear or zero consume result passes
// through the command queue and then the result register. A consume that pops
// descriptors steps through S_TRIM and S_FETCH for each pop, plus a final S_TRIM
// for a partial trim, skipping S_FETCH when it empties the queue; the pop loop
// is set by the registered read of the descriptor store, which refills the cached head.
// Push and clear sustain one item per cycle while out_chan.ready stays high.
// A two-entry command queue keeps accepting items while the result register
// waits on a stalled receiver; once it fills, in_chan.ready drops.
// Reset (rst_n low, synchronous) empties the queue and drops any result in
// flight. The descriptor store needs no clearing pass.
`include "chunk_descriptor_byte_queue_macros.svh"

module chunk_descriptor_byte_queue import cdbq_pkg::*; #(
  parameter int DEPTH    = 16,
  parameter int LEN_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  cdbq_in_if.sink    in_chan,
  cdbq_out_if.source out_chan
);

  logic       cmd_valid;
  logic       cmd_ready;
  cmd_t       cmd;
  back_stat_t stat;

  cdbq_front #(
    .LEN_BITS (LEN_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready)
  );

  cdbq_back #(
    .DEPTH    (DEPTH),
    .LEN_BITS (LEN_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready),
    .out_chan  (out_chan),
    .stat      (stat)
  );

  // Queue bookkeeping and reported results stay consistent
  `CDBQ_ASSERT_ALWAYS(a_empty_total, stat.q_empty == stat.total_zero, "entry count and byte total disagree")
  `CDBQ_ASSERT_IMPLY(a_front_total, out_chan.valid, out_chan.front_valid == (out_chan.queued_total != '0), "front valid disagrees with total")
  `CDBQ_ASSERT_IMPLY(a_head_len, out_chan.valid && out_chan.front_valid, out_chan.front_length != '0, "head chunk reported with zero length")

endmodule
